// ----- sv/bole_pkg.sv -----
package bole_pkg;

  localparam int CAPACITY = 32;
  localparam int VAL_W = 32;
  localparam int POS_W = 6;
  localparam int OUT_IDX_W = 5;
  localparam int OUT_CNT_W = 6;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Width that holds both a position and a count for comparisons.
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [3:0] {
    OP_INS_FRONT = 4'd0,
    OP_INS_BACK  = 4'd1,
    OP_INS_AT    = 4'd2,
    OP_REM_FRONT = 4'd3,
    OP_REM_BACK  = 4'd4,
    OP_REM_AT    = 4'd5,
    OP_SEARCH    = 4'd6,
    OP_PEEK_HEAD = 4'd7,
    OP_PEEK_TAIL = 4'd8,
    OP_CLEAR     = 4'd9
  } op_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic                    go;
    logic                    ins;
    logic                    rem;
    logic                    rd;
    logic [CMP_W-1:0]        tgt;
    logic [CMP_W-1:0]        cnt;
    logic signed [VAL_W-1:0] val;
  } ctrl_t;

endpackage

// ----- sv/bole_cell.sv -----
// One list slot. It shifts toward the tail on an insert, toward the head on
// a removal, and snapshots its old value and a compare result per item.
module bole_cell (
  input  logic                               clk,
  input  bole_pkg::ctrl_t                    ctrl,
  input  logic [bole_pkg::CMP_W-1:0]         cell_idx,
  input  logic signed [bole_pkg::VAL_W-1:0]  left_val,
  input  logic signed [bole_pkg::VAL_W-1:0]  right_val,
  output logic signed [bole_pkg::VAL_W-1:0]  ent_val,
  output logic                               match,
  output logic signed [bole_pkg::VAL_W-1:0]  sel_val
);

  logic signed [bole_pkg::VAL_W-1:0] ent_r;
  logic signed [bole_pkg::VAL_W-1:0] ent_nxt;
  logic                              match_r;
  logic                              match_nxt;
  logic signed [bole_pkg::VAL_W-1:0] sel_r;
  logic signed [bole_pkg::VAL_W-1:0] sel_nxt;

  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.ins) begin
      if (cell_idx == ctrl.tgt) begin
        ent_nxt = ctrl.val;
      end else if (cell_idx > ctrl.tgt) begin
        ent_nxt = left_val;
      end
    end else if (ctrl.rem && (cell_idx >= ctrl.tgt)) begin
      ent_nxt = right_val;
    end
  end

  assign match_nxt = (ent_r == ctrl.val) && (cell_idx < ctrl.cnt);
  assign sel_nxt = (ctrl.rd && (cell_idx == ctrl.tgt)) ? ent_r : '0;

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (ctrl.go) begin
      match_r <= match_nxt;
      sel_r   <= sel_nxt;
    end
  end

  assign ent_val = ent_r;
  assign match   = match_r;
  assign sel_val = sel_r;

endmodule

// ----- sv/bounded_ordered_list_engine.sv -----
// The cells register each accepted item's shifts, compare and read flags;
// the output register then takes the one result reduced from those flags.
// No new item is taken while one is in flight or a result waits stalled.
// Reset (rst_n, synchronous, active low) empties the list and drops any
// pending result; entry storage is not cleared and is never read unwritten.
module bounded_ordered_list_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [3:0]                          in_operation,
  input  logic [bole_pkg::POS_W-1:0]          in_position,
  input  logic signed [bole_pkg::VAL_W-1:0]   in_item_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_ok,
  output logic signed [bole_pkg::VAL_W-1:0]   out_read_value,
  output logic [bole_pkg::OUT_IDX_W-1:0]      out_found_index,
  output logic [bole_pkg::OUT_CNT_W-1:0]      out_entry_count,
  output logic                                out_is_empty
);

  localparam int N = bole_pkg::CAPACITY;
  localparam int CW = bole_pkg::CMP_W;

  // Control and first-cycle bookkeeping.
  logic                         busy_r;
  logic [bole_pkg::CNT_W-1:0]   count_r;
  logic [bole_pkg::CNT_W-1:0]   count_nxt;
  logic                         ok_pre_r;
  logic                         ok_pre_nxt;
  logic                         srch_r;
  logic                         srch_nxt;

  // Output register.
  logic                              out_valid_r;
  logic                              out_ok_r;
  logic signed [bole_pkg::VAL_W-1:0] out_val_r;
  logic [bole_pkg::OUT_IDX_W-1:0]    out_idx_r;
  logic [bole_pkg::OUT_CNT_W-1:0]    out_cnt_r;
  logic                              out_empty_r;

  logic            accept;
  bole_pkg::ctrl_t ctrl;
  bole_pkg::op_t   op;
  logic [CW-1:0]   cnt_x;
  logic [CW-1:0]   pos_x;
  logic [CW-1:0]   cap_x;
  logic            room;
  logic            ins_ok;
  logic            rem_ok;
  logic            rd_ok;
  logic [CW-1:0]   tgt;
  logic            do_ins;
  logic            do_rem;
  logic            do_rd;

  logic signed [bole_pkg::VAL_W-1:0] ent_vals [N];
  logic signed [bole_pkg::VAL_W-1:0] sel_vals [N];
  logic [N-1:0]                      match_vec;

  logic signed [bole_pkg::VAL_W-1:0] rd_val;
  logic [bole_pkg::IDX_W-1:0]        hit_idx;
  logic                              hit;

  // A new item is taken only when nothing is in flight and the output
  // register is empty or is being emptied at this edge.
  assign in_stall = busy_r || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  assign op    = bole_pkg::op_t'(in_operation);
  assign cnt_x = CW'(count_r);
  assign pos_x = CW'(in_position);
  assign cap_x = CW'(N);
  assign room  = cnt_x < cap_x;

  // Decode the operation into a target slot and shift or read requests.
  // A removal also reads, since it returns the slot's old value.
  always_comb begin
    tgt        = '0;
    ins_ok     = 1'b0;
    rem_ok     = 1'b0;
    rd_ok      = 1'b0;
    srch_nxt   = 1'b0;
    ok_pre_nxt = 1'b0;
    count_nxt  = count_r;
    case (op)
      bole_pkg::OP_INS_FRONT: begin
        ins_ok = room;
      end
      bole_pkg::OP_INS_BACK: begin
        tgt    = cnt_x;
        ins_ok = room;
      end
      bole_pkg::OP_INS_AT: begin
        tgt    = pos_x;
        ins_ok = room && (pos_x <= cnt_x);
      end
      bole_pkg::OP_REM_FRONT: begin
        rem_ok = (cnt_x != '0);
      end
      bole_pkg::OP_REM_BACK: begin
        tgt    = cnt_x - CW'(1);
        rem_ok = (cnt_x != '0);
      end
      bole_pkg::OP_REM_AT: begin
        tgt    = pos_x;
        rem_ok = (pos_x < cnt_x);
      end
      bole_pkg::OP_SEARCH: begin
        srch_nxt = 1'b1;
      end
      bole_pkg::OP_PEEK_HEAD: begin
        rd_ok = (cnt_x != '0);
      end
      bole_pkg::OP_PEEK_TAIL: begin
        tgt   = cnt_x - CW'(1);
        rd_ok = (cnt_x != '0);
      end
      bole_pkg::OP_CLEAR: begin
        count_nxt  = '0;
        ok_pre_nxt = 1'b1;
      end
      default: begin
      end
    endcase
    if (ins_ok) begin
      count_nxt  = count_r + bole_pkg::CNT_W'(1);
      ok_pre_nxt = 1'b1;
    end
    if (rem_ok) begin
      count_nxt  = count_r - bole_pkg::CNT_W'(1);
      ok_pre_nxt = 1'b1;
    end
    if (rd_ok) begin
      ok_pre_nxt = 1'b1;
    end
  end

  assign do_ins = accept && ins_ok;
  assign do_rem = accept && rem_ok;
  assign do_rd  = accept && (rem_ok || rd_ok);

  assign ctrl.go  = accept;
  assign ctrl.ins = do_ins;
  assign ctrl.rem = do_rem;
  assign ctrl.rd  = do_rd;
  assign ctrl.tgt = tgt;
  assign ctrl.cnt = cnt_x;
  assign ctrl.val = in_item_value;

  // The row of cells. Each cell sees its two neighbors; the head cell's left
  // input is never selected, and the tail cell's right input is its own entry.
  for (genvar g = 0; g < N; g++) begin : g_cell
    logic signed [bole_pkg::VAL_W-1:0] lv;
    logic signed [bole_pkg::VAL_W-1:0] rv;
    if (g == 0) begin : g_head
      assign lv = in_item_value;
    end else begin : g_mid_l
      assign lv = ent_vals[g-1];
    end
    if (g == N - 1) begin : g_tail
      assign rv = ent_vals[g];
    end else begin : g_mid_r
      assign rv = ent_vals[g+1];
    end
    bole_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .cell_idx  (CW'(g)),
      .left_val  (lv),
      .right_val (rv),
      .ent_val   (ent_vals[g]),
      .match     (match_vec[g]),
      .sel_val   (sel_vals[g])
    );
  end

  // From the registered cell flags: at most one cell holds a nonzero read
  // snapshot, so an OR gathers it; the lowest matching cell wins a search.
  always_comb begin
    rd_val  = '0;
    hit_idx = '0;
    hit     = 1'b0;
    for (int i = 0; i < N; i++) begin
      rd_val = rd_val | sel_vals[i];
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit_idx = bole_pkg::IDX_W'(i);
        hit     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (accept) begin
        busy_r   <= 1'b1;
        count_r  <= count_nxt;
        ok_pre_r <= ok_pre_nxt;
        srch_r   <= srch_nxt;
      end
      if (busy_r) begin
        busy_r      <= 1'b0;
        out_valid_r <= 1'b1;
        out_ok_r    <= srch_r ? hit : ok_pre_r;
        out_val_r   <= rd_val;
        out_idx_r   <= (srch_r && hit) ? bole_pkg::OUT_IDX_W'(hit_idx) : '0;
        out_cnt_r   <= bole_pkg::OUT_CNT_W'(count_r);
        out_empty_r <= (count_r == '0);
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_read_value  = out_val_r;
  assign out_found_index = out_idx_r;
  assign out_entry_count = out_cnt_r;
  assign out_is_empty    = out_empty_r;

endmodule

// ----- sv/bole_checker.sv -----
module bole_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic [3:0]                          in_operation,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                out_ok,
  input logic signed [bole_pkg::VAL_W-1:0]   out_read_value,
  input logic [bole_pkg::OUT_IDX_W-1:0]      out_found_index,
  input logic [bole_pkg::OUT_CNT_W-1:0]      out_entry_count,
  input logic                                out_is_empty
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_value)
      && $stable(out_entry_count))
    else $error("result changed while stalled");

  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_entry_count == '0)))
    else $error("empty flag disagrees with count");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> (out_read_value == '0) && (out_found_index == '0))
    else $error("failed item carries data");

  // A clear yields an empty, successful result.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_operation == bole_pkg::OP_CLEAR)
      |-> ##2 out_valid && out_ok && out_is_empty)
    else $error("clear result wrong");

endmodule

bind bounded_ordered_list_engine bole_checker u_bole_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_operation    (in_operation),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_ok          (out_ok),
  .out_read_value  (out_read_value),
  .out_found_index (out_found_index),
  .out_entry_count (out_entry_count),
  .out_is_empty    (out_is_empty)
);

// ----- sim/bounded_ordered_list_engine_tb.sv -----
module bounded_ordered_list_engine_tb;
  import bole_pkg::*;

  // Selector codes that the block must treat as a no-op.
  localparam logic [3:0] OP_UNUSED_LO = 4'd10;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;

  // Roughly how many items the run sends, the directed ones included.
  localparam int RANDOM_ITEMS = 950;
  // Results taken before the long receiver hold-off, and its length in cycles.
  localparam int HOLDOFF_AT = 150;
  localparam int HOLDOFF_LEN = 300;
  // Cycles without any handshake before the run is declared hung. The long
  // hold-off is the slowest stretch of a correct run, so this is several times it.
  localparam int IDLE_LIMIT = 2000;
  // Cycles to let pass after the last result.
  localparam int DRAIN_CYCLES = 8;
  // Mismatch lines printed before the report task goes quiet and only counts.
  localparam int MAX_REPORTS = 40;

  // One command for the list as the sender holds it.
  typedef struct {
    logic [3:0]              op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
  } list_cmd_t;

  // One reply of the list, with the block's output widths.
  typedef struct packed {
    logic                    ok;
    logic signed [VAL_W-1:0] rd;
    logic [OUT_IDX_W-1:0]    idx;
    logic [OUT_CNT_W-1:0]    cnt;
    logic                    empty;
  } list_reply_t;

  // Receiver stall patterns, one picked at random for each phase.
  typedef enum {RX_OPEN, RX_RANDOM, RX_TOGGLE, RX_HEAVY} rx_mode_t;

  // Kinds of command sequences the stimulus is built from.
  typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIXED, SEG_NOISE, SEG_FULL_CYCLE} seg_kind_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [3:0]              in_operation = '0;
  logic [POS_W-1:0]        in_position = '0;
  logic signed [VAL_W-1:0] in_item_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_ok;
  logic signed [VAL_W-1:0] out_read_value;
  logic [OUT_IDX_W-1:0]    out_found_index;
  logic [OUT_CNT_W-1:0]    out_entry_count;
  logic                    out_is_empty;

  bounded_ordered_list_engine DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_position    (in_position),
    .in_item_value  (in_item_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ok         (out_ok),
    .out_read_value (out_read_value),
    .out_found_index(out_found_index),
    .out_entry_count(out_entry_count),
    .out_is_empty   (out_is_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the list. Every accepted item is applied to it in the order
  // of acceptance, and the reply it yields is queued for the monitor.
  // ---------------------------------------------------------------------------
  logic signed [VAL_W-1:0] model_entries [0:CAPACITY-1];
  int unsigned             model_count = 0;
  list_reply_t             predicted_replies [$];

  // Inserting shifts everything from the position onward one slot toward the
  // tail. A full list or a position past the count leaves the list untouched.
  function automatic bit list_insert(int unsigned at, logic signed [VAL_W-1:0] v);
    int unsigned i;
    if (model_count >= CAPACITY || at > model_count) return 1'b0;
    for (i = model_count; i > at; i--) model_entries[i] = model_entries[i-1];
    model_entries[at] = v;
    model_count++;
    return 1'b1;
  endfunction

  // Removal hands back the entry and closes the gap toward the head.
  function automatic bit list_remove(int unsigned at, output logic signed [VAL_W-1:0] v);
    int unsigned i;
    v = '0;
    if (model_count == 0 || at >= model_count) return 1'b0;
    v = model_entries[at];
    for (i = at; i + 1 < model_count; i++) model_entries[i] = model_entries[i+1];
    model_count--;
    return 1'b1;
  endfunction

  function automatic list_reply_t apply_list_op(logic [3:0] op, logic [POS_W-1:0] pos,
                                                logic signed [VAL_W-1:0] v);
    list_reply_t             r;
    logic signed [VAL_W-1:0] taken;
    int unsigned             i;
    r = '0;
    taken = '0;
    case (op)
      OP_INS_FRONT: r.ok = list_insert(0, v);
      OP_INS_BACK:  r.ok = list_insert(model_count, v);
      OP_INS_AT:    r.ok = list_insert(pos, v);
      OP_REM_FRONT: r.ok = list_remove(0, taken);
      OP_REM_BACK: begin
        if (model_count > 0) r.ok = list_remove(model_count - 1, taken);
      end
      OP_REM_AT:    r.ok = list_remove(pos, taken);
      OP_SEARCH: begin
        // The lowest matching index wins, so the scan stops at the first hit.
        for (i = 0; i < model_count && !r.ok; i++) begin
          if (model_entries[i] == v) begin
            r.ok = 1'b1;
            r.idx = i[OUT_IDX_W-1:0];
          end
        end
      end
      OP_PEEK_HEAD: begin
        if (model_count > 0) begin
          r.ok = 1'b1;
          taken = model_entries[0];
        end
      end
      OP_PEEK_TAIL: begin
        if (model_count > 0) begin
          r.ok = 1'b1;
          taken = model_entries[model_count-1];
        end
      end
      OP_CLEAR: begin
        model_count = 0;
        r.ok = 1'b1;
      end
      default: begin
        // Unused selectors change nothing and only report the count.
      end
    endcase
    r.rd = r.ok ? taken : '0;
    r.cnt = model_count[OUT_CNT_W-1:0];
    r.empty = (model_count == 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting. Every failure is counted; only the first few print.
  // ---------------------------------------------------------------------------
  int error_count = 0;
  int replies_checked = 0;

  task automatic report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("ERROR reply %0d: %s got 0x%0h expected 0x%0h",
               replies_checked, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus. The initial block below fills this queue before reset ends and
  // the driver drains it one item per handshake.
  // ---------------------------------------------------------------------------
  list_cmd_t               pending_cmds [$];
  logic signed [VAL_W-1:0] value_pool [0:7];
  int                      total_items = 0;

  task automatic add_cmd(logic [3:0] op, logic [POS_W-1:0] pos, logic signed [VAL_W-1:0] v);
    list_cmd_t c;
    c.op = op;
    c.pos = pos;
    c.val = v;
    pending_cmds.push_back(c);
  endtask

  // Values are drawn mostly from a small pool so that searches hit, with the
  // signed extremes and fully random words mixed in.
  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = value_pool[$urandom_range(0, 7)];
      5:             v = 32'sh7FFF_FFFF;
      6:             v = 32'sh8000_0000;
      default:       v = $urandom;
    endcase
    return v;
  endfunction

  // Picks one selector out of a run of consecutive codes.
  function automatic logic [3:0] pick_op(logic [3:0] first, int span);
    logic [3:0] op;
    op = first + $urandom_range(0, span - 1);
    return op;
  endfunction

  // Positions mostly fall near the useful range, sometimes anywhere the
  // six-bit field reaches.
  function automatic logic [POS_W-1:0] pick_pos();
    logic [POS_W-1:0] p;
    if ($urandom_range(0, 7) == 0) p = $urandom_range(0, 63);
    else p = $urandom_range(0, CAPACITY);
    return p;
  endfunction

  task automatic build_stimulus();
    int        n;
    int        k;
    int        roll;
    seg_kind_t kind;
    logic [3:0] op;
    for (k = 0; k < 8; k++) value_pool[k] = $urandom;

    // Directed part: each non-insert case on an empty list, then a short life cycle
    // that touches both ends, the append-at-count case and bad positions.
    add_cmd(OP_PEEK_HEAD, 0, 0);
    add_cmd(OP_PEEK_TAIL, 0, 0);
    add_cmd(OP_REM_FRONT, 0, 0);
    add_cmd(OP_REM_BACK, 0, 0);
    add_cmd(OP_REM_AT, 0, 0);
    add_cmd(OP_SEARCH, 0, 0);
    add_cmd(OP_CLEAR, 0, 0);
    add_cmd(OP_UNUSED_LO, 6'd63, 32'sh7FFF_FFFF);
    add_cmd(OP_INS_AT, 1, 7);
    add_cmd(OP_INS_FRONT, 0, 32'sh7FFF_FFFF);
    add_cmd(OP_INS_BACK, 0, 32'sh8000_0000);
    add_cmd(OP_INS_AT, 1, -1);
    add_cmd(OP_INS_AT, 3, 0);
    add_cmd(OP_INS_AT, 6'd63, 5);
    add_cmd(OP_SEARCH, 0, -1);
    add_cmd(OP_SEARCH, 0, 12345);
    add_cmd(OP_PEEK_HEAD, 0, 0);
    add_cmd(OP_PEEK_TAIL, 0, 0);
    add_cmd(OP_REM_AT, 6'd63, 0);
    add_cmd(OP_REM_AT, 4, 0);
    add_cmd(OP_REM_AT, 1, 0);
    add_cmd(OP_UNUSED_HI, 6'd42, -1);
    add_cmd(OP_REM_BACK, 0, 0);
    add_cmd(OP_REM_FRONT, 0, 0);
    add_cmd(OP_CLEAR, 0, 0);

    // Random part, built from sequences so that the list really grows to full
    // and shrinks to empty instead of hovering near a small count.
    while (pending_cmds.size() < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 11);
      if (roll < 3) kind = SEG_FILL;
      else if (roll < 6) kind = SEG_DRAIN;
      else if (roll < 10) kind = SEG_MIXED;
      else if (roll < 11) kind = SEG_NOISE;
      else kind = SEG_FULL_CYCLE;
      case (kind)
        SEG_FILL: begin
          n = $urandom_range(20, 40);
          for (k = 0; k < n; k++) add_cmd(pick_op(OP_INS_FRONT, 3), pick_pos(), pick_value());
        end
        SEG_DRAIN: begin
          n = $urandom_range(15, 40);
          for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 4) == 0) op = pick_op(OP_SEARCH, 3);
            else op = pick_op(OP_REM_FRONT, 3);
            add_cmd(op, pick_pos(), pick_value());
          end
        end
        SEG_MIXED: begin
          n = $urandom_range(10, 30);
          for (k = 0; k < n; k++) begin
            op = pick_op(OP_INS_FRONT, 10);
            // Clears would keep the list near empty, so most become searches.
            if (op == OP_CLEAR && $urandom_range(0, 3) != 0) op = OP_SEARCH;
            add_cmd(op, pick_pos(), pick_value());
          end
        end
        SEG_NOISE: begin
          n = $urandom_range(3, 10);
          for (k = 0; k < n; k++)
            add_cmd($urandom_range(0, 15), $urandom_range(0, 63), $urandom);
        end
        SEG_FULL_CYCLE: begin
          // Fill from empty past capacity so that inserts into a full list
          // fail, probe the full list, then empty it again one end at a time.
          add_cmd(OP_CLEAR, 0, 0);
          for (k = 0; k <= CAPACITY; k++) add_cmd(OP_INS_BACK, 0, pick_value());
          add_cmd(OP_INS_FRONT, 0, pick_value());
          add_cmd(OP_INS_AT, CAPACITY, pick_value());
          add_cmd(OP_PEEK_TAIL, 0, 0);
          add_cmd(OP_SEARCH, 0, pick_value());
          add_cmd(OP_REM_AT, CAPACITY - 1, 0);
          add_cmd(OP_INS_AT, CAPACITY - 1, pick_value());
          for (k = 0; k <= CAPACITY; k++) add_cmd(pick_op(OP_REM_FRONT, 2), 0, 0);
        end
        default: ;
      endcase
    end
    total_items = pending_cmds.size();
  endtask

  // ---------------------------------------------------------------------------
  // Driver. It offers items in bursts of random length separated by random
  // gaps, some of length zero, so long runs without idling occur as well. An
  // item that is stalled stays on the ports unchanged until it is accepted.
  // ---------------------------------------------------------------------------
  int        burst_left = 1;
  int        gap_left = 0;
  list_cmd_t next_cmd;

  always @(posedge clk) begin
    if (rst_n && !(in_valid && in_stall)) begin
      // Whatever was offered has just been taken, or nothing was offered.
      if (gap_left > 0 || pending_cmds.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        next_cmd = pending_cmds.pop_front();
        in_operation <= next_cmd.op;
        in_position <= next_cmd.pos;
        in_item_value <= next_cmd.val;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. It switches at random between stall patterns of its own. Once,
  // after enough replies, it holds off for a long stretch while the driver
  // keeps offering, so the block fills up and stalls its input.
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_phase_left = 0;
  int       replies_taken = 0;
  int       holdoff_left = 0;
  bit       holdoff_done = 1'b0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) replies_taken++;
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else if (!holdoff_done && replies_taken >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_LEN;
        out_stall <= 1'b1;
      end else begin
        if (rx_phase_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          rx_phase_left = $urandom_range(20, 80);
        end
        rx_phase_left--;
        case (rx_mode)
          RX_OPEN:   out_stall <= 1'b0;
          RX_RANDOM: out_stall <= $urandom_range(0, 1);
          RX_TOGGLE: out_stall <= ~out_stall;
          RX_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
          default:   out_stall <= 1'b0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. An accepted input item is applied to the shadow list first, so
  // the queue already holds its reply whenever the block can produce it. An
  // accepted reply is then compared field by field with the oldest one queued.
  // ---------------------------------------------------------------------------
  int          items_accepted = 0;
  list_reply_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predicted_replies.push_back(apply_list_op(in_operation, in_position, in_item_value));
        items_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (predicted_replies.size() == 0) begin
          report_mismatch("reply with no item pending, entry_count", out_entry_count, 0);
        end else begin
          want = predicted_replies.pop_front();
          if (out_ok !== want.ok) report_mismatch("ok", out_ok, want.ok);
          if (out_read_value !== want.rd) report_mismatch("read_value", out_read_value, want.rd);
          if (out_found_index !== want.idx)
            report_mismatch("found_index", out_found_index, want.idx);
          if (out_entry_count !== want.cnt)
            report_mismatch("entry_count", out_entry_count, want.cnt);
          if (out_is_empty !== want.empty)
            report_mismatch("is_empty", out_is_empty, want.empty);
        end
        replies_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog. Any stretch without a handshake on either side longer than the
  // limit means the block has hung.
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: build the stimulus, hold reset, then wait for every item to
  // be taken and every reply to come back. The check runs on the falling edge
  // so that it sees the settled result of each rising edge.
  // ---------------------------------------------------------------------------
  initial begin
    build_stimulus();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (!(items_accepted == total_items && predicted_replies.size() == 0)) @(negedge clk);
    // The drain wait catches any reply the block produces without an item.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predicted_replies.size() != 0)
      report_mismatch("replies missing at end, count", predicted_replies.size(), 0);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- bounded_ordered_list_engine.f -----
sv/bole_pkg.sv
sv/bole_cell.sv
sv/bounded_ordered_list_engine.sv
sv/bole_checker.sv
sim/bounded_ordered_list_engine_tb.sv
